// File: hdl/tfdc_pkg.sv
package tfdc_pkg;

    localparam int COUNT_WIDTH   = 8;
    localparam int PORT_BOUNDARY = 1024;
    localparam int PORT_W        = 16;
    localparam int TABLE_DEPTH   = (1 << PORT_W) - PORT_BOUNDARY;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;

    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  FLAGS_SYN_ACK = 8'h12;
    localparam logic [7:0]  FLAGS_FIN_ACK = 8'h11;
    localparam logic [7:0]  FLAG_RST      = 8'h04;

    localparam logic [1:0] DIR_ANY = 2'd0;
    localparam logic [1:0] DIR_C2S = 2'd1;
    localparam logic [1:0] DIR_S2C = 2'd2;

    typedef struct packed {
        logic [15:0]       frame_length;
        logic [7:0]        tcp_flag_bits;
        logic [PORT_W-1:0] dest_port;
        logic [PORT_W-1:0] source_port;
        logic [7:0]        ip_protocol;
        logic [15:0]       eth_type;
    } t_item;

    typedef struct packed {
        logic [15:0]       out_length;
        logic [1:0]        direction;
        logic [PORT_W-1:0] out_dest_port;
        logic [PORT_W-1:0] out_source_port;
        logic [7:0]        protocol_class;
        logic              is_ipv4;
    } t_res;

    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       addr;
        logic [COUNT_WIDTH-1:0] data;
    } t_wr;

    function automatic logic port_is_dynamic(input logic [PORT_W-1:0] port);
        return port > PORT_W'(PORT_BOUNDARY);
    endfunction

    function automatic logic [IDX_W-1:0] port_slot(input logic [PORT_W-1:0] port);
        logic [PORT_W-1:0] diff;
        diff = port - PORT_W'(PORT_BOUNDARY);
        return port_is_dynamic(port) ? IDX_W'(diff) : '0;
    endfunction

endpackage

// File: hdl/tfdc_count_mem.sv
module tfdc_count_mem
    import tfdc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_wr                    i_wr,
    input  logic                   i_rd_en,
    input  logic [IDX_W-1:0]       i_rd_addr_a,
    input  logic [IDX_W-1:0]       i_rd_addr_b,
    output logic [COUNT_WIDTH-1:0] o_rd_data_a,
    output logic [COUNT_WIDTH-1:0] o_rd_data_b,
    output logic                   o_busy
);

    logic [COUNT_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_a;
    logic [COUNT_WIDTH-1:0] r_rd_b;
    logic                   r_clr_busy;
    logic [IDX_W-1:0]       r_clr_idx;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign wr_en   = r_clr_busy | i_wr.en;
    assign wr_addr = r_clr_busy ? r_clr_idx : i_wr.addr;
    assign wr_data = r_clr_busy ? '0 : i_wr.data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;
    assign o_busy      = r_clr_busy;

endmodule

// File: hdl/tfdc_classify.sv
module tfdc_classify
    import tfdc_pkg::*;
(
    input  t_item                  i_item,
    input  logic [IDX_W-1:0]       i_sidx,
    input  logic [IDX_W-1:0]       i_didx,
    input  logic [COUNT_WIDTH-1:0] i_rd_s,
    input  logic [COUNT_WIDTH-1:0] i_rd_d,
    input  t_wr                    i_fwd,
    output t_wr                    o_wr,
    output t_res                   o_res
);

    logic                   is_ip;
    logic                   tcp;
    logic                   udp;
    logic                   icmp;
    logic                   sdyn;
    logic                   ddyn;
    logic                   syn;
    logic                   fin;
    logic [COUNT_WIDTH-1:0] cnt_s;
    logic [COUNT_WIDTH-1:0] cnt_d;
    logic [COUNT_WIDTH-1:0] upd_s;
    logic [COUNT_WIDTH-1:0] upd_d;
    logic [1:0]             lower_dir;

    always_comb begin
        is_ip = i_item.eth_type == ETH_IPV4;
        tcp   = i_item.ip_protocol == PROTO_TCP;
        udp   = i_item.ip_protocol == PROTO_UDP;
        icmp  = i_item.ip_protocol == PROTO_ICMP;
        sdyn  = port_is_dynamic(i_item.source_port);
        ddyn  = port_is_dynamic(i_item.dest_port);
        syn   = i_item.tcp_flag_bits == FLAGS_SYN_ACK;
        fin   = !syn && (i_item.tcp_flag_bits == FLAGS_FIN_ACK ||
                         (i_item.tcp_flag_bits & FLAG_RST) != 8'd0);

        // bypass the write that landed on the same edge as this read
        cnt_s = (i_fwd.en && i_fwd.addr == i_sidx) ? i_fwd.data : i_rd_s;
        cnt_d = (i_fwd.en && i_fwd.addr == i_didx) ? i_fwd.data : i_rd_d;

        o_wr.en   = is_ip && tcp && ((syn && sdyn) || (fin && ddyn));
        o_wr.addr = syn ? i_sidx : i_didx;
        if (syn) begin
            o_wr.data = (&cnt_s) ? cnt_s : cnt_s + 1'b1;
        end else begin
            o_wr.data = (cnt_d == '0) ? cnt_d : cnt_d - 1'b1;
        end

        upd_s = (o_wr.en && o_wr.addr == i_sidx) ? o_wr.data : cnt_s;
        upd_d = (o_wr.en && o_wr.addr == i_didx) ? o_wr.data : cnt_d;

        lower_dir = (i_item.source_port < i_item.dest_port) ? DIR_S2C : DIR_C2S;

        o_res = '0;
        if (is_ip) begin
            o_res.is_ipv4    = 1'b1;
            o_res.out_length = i_item.frame_length;
            if (tcp || udp) begin
                o_res.protocol_class  = i_item.ip_protocol;
                o_res.out_source_port = i_item.source_port;
                o_res.out_dest_port   = i_item.dest_port;
                if (!(sdyn && ddyn)) begin
                    o_res.direction = lower_dir;
                end else if (tcp) begin
                    if (upd_d != '0) begin
                        o_res.direction = DIR_C2S;
                    end else if (upd_s != '0) begin
                        o_res.direction = DIR_S2C;
                    end
                end
            end else if (icmp) begin
                o_res.protocol_class = PROTO_ICMP;
            end
        end
    end

endmodule

// File: hdl/tcp_flow_direction_classifier.sv
// Classifies one parsed frame header per transfer and keeps a saturating
// counter per dynamic port in a single on-chip table (two read ports, one
// write port). A new header can be taken every cycle while the output is not
// stalled; the table read is registered on the accepting edge, and the
// updated and classified record is then loaded into the output register once
// the output stage can advance. Back-to-back updates of the same port are
// bypassed. After reset all 64512 table entries are cleared, one entry per
// cycle; s_axis_tready stays low until that pass ends.
module tcp_flow_direction_classifier
    import tfdc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // eth_type, ip_protocol, source_port, dest_port, tcp_flag_bits, frame_length
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // is_ipv4, protocol_class, out_source_port, out_dest_port, direction,
    // out_length, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_item                  in_item;
    logic                   accept;
    logic                   s1_adv;
    logic                   busy;
    logic                   r_s1_v;
    t_item                  r_s1_item;
    logic [IDX_W-1:0]       r_s1_sidx;
    logic [IDX_W-1:0]       r_s1_didx;
    t_wr                    r_fwd;
    logic                   r_o_v;
    t_res                   r_res;
    logic [COUNT_WIDTH-1:0] rd_s;
    logic [COUNT_WIDTH-1:0] rd_d;
    t_wr                    cls_wr;
    t_wr                    mem_wr;
    t_res                   cls_res;

    assign in_item       = t_item'(s_axis_tdata);
    assign s1_adv        = !r_o_v || m_axis_tready;
    assign s_axis_tready = !busy && (!r_s1_v || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        mem_wr    = cls_wr;
        mem_wr.en = cls_wr.en && r_s1_v && s1_adv;
    end

    tfdc_count_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (mem_wr),
        .i_rd_en     (accept),
        .i_rd_addr_a (port_slot(in_item.source_port)),
        .i_rd_addr_b (port_slot(in_item.dest_port)),
        .o_rd_data_a (rd_s),
        .o_rd_data_b (rd_d),
        .o_busy      (busy)
    );

    tfdc_classify u_cls (
        .i_item (r_s1_item),
        .i_sidx (r_s1_sidx),
        .i_didx (r_s1_didx),
        .i_rd_s (rd_s),
        .i_rd_d (rd_d),
        .i_fwd  (r_fwd),
        .o_wr   (cls_wr),
        .o_res  (cls_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
            r_fwd  <= '0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
                r_fwd  <= mem_wr;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (r_s1_v && s1_adv) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= in_item;
            r_s1_sidx <= port_slot(in_item.source_port);
            r_s1_didx <= port_slot(in_item.dest_port);
        end
        if (r_s1_v && s1_adv) begin
            r_res <= cls_res;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_res))'(0), r_res};

endmodule
